// ----- rtl/lbs_pkg.sv -----
`default_nettype none
package lbs_pkg;
   localparam int unsigned BONES     = 64;
   localparam int unsigned FRAC_BITS = 16;
   localparam int unsigned MAT_WORDS = 12;
   localparam int unsigned MAT_DEPTH = BONES * MAT_WORDS;
   localparam int unsigned MAT_AW    = $clog2(MAT_DEPTH);
   localparam int unsigned BONE_W    = 6;
   localparam int unsigned WSUM_W    = 24;
   localparam logic [WSUM_W-1:0] WSUM_MAX = '1;

   localparam logic OP_LOAD      = 1'b0;
   localparam logic OP_INFLUENCE = 1'b1;

   // Request payload, last field in the lowest bits, padded to whole bytes.
   typedef struct packed {
      logic        [3:0]  pad;
      logic        [16:0] vertex_mask;
      logic        [16:0] weight;
      logic signed [31:0] pos_z;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_x;
      logic signed [31:0] matrix_word;
      logic        [3:0]  word;
      logic        [BONE_W-1:0] bone;
   } req_data_type;

   typedef struct packed {
      logic signed [31:0] out_z;
      logic signed [31:0] out_y;
      logic signed [31:0] out_x;
   } rsp_data_type;

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63])
         s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      return s;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      if (x > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
      if (x < -64'sh80000000) return 32'sh80000000;
      return x[31:0];
   endfunction
endpackage
`default_nettype wire

// ----- rtl/linear_blend_skinning_top.sv -----
`default_nettype none
// Linear blend skinning, Q16.16 fixed point.
// The request channel (req_) carries two kinds of request, chosen by tuser:
// a load (0) writes one word of a 3x4 bone matrix table, an influence (1)
// applies one bone to the vertex position with a weight. Influences of one
// vertex arrive in a row; tlast marks the final one, which produces one
// response on the rsp_ channel (tuser is the moved flag).
// A load is taken in idle and written to the table in ST_LOAD. An influence
// is taken in idle; the sequencer then makes twelve matrix reads and
// multiply-adds, the read data registered, through one shared 33x33 signed
// multiplier and a saturating 64-bit adder, then scales the three axis deltas
// by the weight on the same multiplier. The final influence adds a restoring
// division, one quotient bit per cycle, for each of the three axes in turn
// through one shared divider; the last axis is stored in ST_OUT before
// rsp_tvalid rises.
// req_tready is low while a request is in work or a response waits to be
// taken; a stalled receiver holds the response register and the block.
// Reset clears the sequencer and the per-vertex sums. The matrix table is not
// cleared: matrix words must be written before an influence uses them.
module linear_blend_skinning_top (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // bone, word, matrix_word, pos_x, pos_y, pos_z, weight, vertex_mask, pad
   input  wire lbs_pkg::req_data_type     req_tdata,
   input  wire logic                      req_tuser,  // opcode
   input  wire logic                      req_tlast,  // last
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output lbs_pkg::rsp_data_type          rsp_tdata,  // out_x, out_y, out_z
   output logic                           rsp_tuser   // moved
);
   import lbs_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0, ST_LOAD = 3'd1, ST_MAC = 3'd2,
                          ST_WGT = 3'd3, ST_DIV = 3'd4, ST_OUT = 3'd5;

   logic [2:0]  state_ff, state_in;
   req_data_type req_ff;
   logic        last_ff;

   // Matrix memory.
   logic signed [31:0] mat_mem [MAT_DEPTH];
   logic signed [31:0] mat_rd_ff;
   logic [MAT_AW-1:0]  mat_addr;
   logic [3:0]  step_ff;      // read slot within the matrix
   logic [3:0]  rd_word;      // matrix word read in this slot
   logic        rd_valid_ff;
   logic        bone_ok;
   assign bone_ok = ({2'b00, req_ff.bone} < 8'(BONES));
   // Each row is read offset column first, then columns 0 to 2, so the row
   // sum starts from the offset term and saturates in that order.
   assign rd_word = {step_ff[3:2], step_ff[1:0] - 2'd1};
   assign mat_addr = MAT_AW'(32'(req_ff.bone) * MAT_WORDS + 32'(rd_word));

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD && bone_ok && req_ff.word < 4'(MAT_WORDS))
         mat_mem[MAT_AW'(32'(req_ff.bone) * MAT_WORDS + 32'(req_ff.word))]
            <= req_ff.matrix_word;
      mat_rd_ff <= mat_mem[mat_addr];
   end

   // Shared multiplier operands.
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   assign mul_p = mul_a * mul_b;

   logic signed [63:0] acc_ff;
   logic signed [32:0] dlt_ff [3];
   logic signed [63:0] dsum_ff [3];
   logic [WSUM_W-1:0]  wsum_ff;
   logic [1:0]         row_ff;
   logic [3:0]         rd_idx_ff;   // word index of mat_rd_ff

   // Divider.
   logic [63:0] dnum_ff, dquo_ff;
   logic [WSUM_W:0] drem_ff;
   logic [5:0]  dbit_ff;
   logic        dneg_ff;
   logic [1:0]  axis_ff;
   logic signed [31:0] res_ff [3];
   logic        moved_ff;

   // Final quotient capture: in the cycle after the last divide step of an axis.
   logic cap_ff;
   logic [1:0] cap_axis_ff;

   logic signed [31:0] pos_sel;
   always_comb begin
      case (rd_idx_ff[1:0])
         2'd0:    pos_sel = req_ff.pos_x;
         2'd1:    pos_sel = req_ff.pos_y;
         2'd2:    pos_sel = req_ff.pos_z;
         default: pos_sel = 32'sd1 <<< FRAC_BITS;
      endcase
   end

   function automatic logic signed [31:0] pos_axis_r(input logic [1:0] a);
      case (a)
         2'd0:    return req_ff.pos_x;
         2'd1:    return req_ff.pos_y;
         default: return req_ff.pos_z;
      endcase
   endfunction

   always_comb begin
      mul_a = {mat_rd_ff[31], mat_rd_ff};
      mul_b = {pos_sel[31], pos_sel};
      if (state_ff == ST_WGT) begin
         mul_a = dlt_ff[row_ff];
         mul_b = {16'd0, req_ff.weight};
      end
   end

   logic signed [63:0] t_shift;
   logic signed [31:0] t_sat;
   logic signed [63:0] acc_fin;
   assign acc_fin = sat_add64(acc_ff, mul_p[63:0]);
   assign t_shift = acc_fin >>> FRAC_BITS;
   assign t_sat   = sat32(t_shift);

   logic [WSUM_W:0] wsum_add;
   assign wsum_add = {1'b0, wsum_ff} + (WSUM_W+1)'(req_ff.weight);

   logic [WSUM_W:0] rem_sh;
   assign rem_sh = {drem_ff[WSUM_W-1:0], dnum_ff[63]};

   logic signed [63:0] dsum_cur;
   assign dsum_cur = dsum_ff[axis_ff];
   logic [63:0] mag;
   assign mag = dsum_cur[63] ? 64'(-dsum_cur) : dsum_cur;
   logic [63:0] qcl;
   assign qcl = (dquo_ff > (64'd1 << 34)) ? (64'd1 << 34) : dquo_ff;
   logic signed [63:0] qs;
   assign qs = dneg_ff ? -$signed(qcl) : $signed(qcl);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_tvalid)
            state_in = (req_tuser == OP_LOAD) ? ST_LOAD : ST_MAC;
         ST_LOAD: state_in = ST_IDLE;
         ST_MAC:  if (!bone_ok || (rd_valid_ff && rd_idx_ff == 4'd10))
            state_in = bone_ok ? ST_WGT : (last_ff ? ST_DIV : ST_IDLE);
         ST_WGT:  if (row_ff == 2'd2) state_in = last_ff ? ST_DIV : ST_IDLE;
         ST_DIV:  if (!div_first_ff && dbit_ff == 6'd0 && axis_ff == 2'd2)
            state_in = ST_OUT;
         ST_OUT:  if (rsp_tvalid && rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // The last axis is stored during the first cycle in ST_OUT, so the
   // response is shown from the cycle after.
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT) && !cap_ff;
   assign rsp_tdata  = '{out_x: res_ff[0], out_y: res_ff[1], out_z: res_ff[2]};
   assign rsp_tuser  = moved_ff;

   logic div_first_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wsum_ff  <= '0;
         for (int i = 0; i < 3; i++) dsum_ff[i] <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE: if (req_tvalid) begin
               req_ff  <= req_tdata;
               last_ff <= req_tlast;
               step_ff <= '0;
               rd_valid_ff <= 1'b0;
               row_ff  <= '0;
               axis_ff <= '0;
               div_first_ff <= 1'b1;
            end
            ST_MAC: begin
               if (step_ff != 4'd11) step_ff <= step_ff + 4'd1;
               rd_idx_ff   <= rd_word;
               rd_valid_ff <= 1'b1;
               if (rd_valid_ff) begin
                  if (rd_idx_ff[1:0] == 2'd3) acc_ff <= mul_p[63:0];
                  else acc_ff <= acc_fin;
                  if (rd_idx_ff[1:0] == 2'd2)
                     dlt_ff[rd_idx_ff[3:2]] <= 33'(t_sat) - 33'(pos_axis_r(rd_idx_ff[3:2]));
               end
            end
            ST_WGT: begin
               dsum_ff[row_ff] <= sat_add64(dsum_ff[row_ff], mul_p[63:0]);
               row_ff <= row_ff + 2'd1;
               if (row_ff == 2'd2)
                  wsum_ff <= wsum_add[WSUM_W] ? WSUM_MAX : wsum_add[WSUM_W-1:0];
            end
            ST_DIV: begin
               if (div_first_ff) begin
                  dnum_ff <= mag; dquo_ff <= '0; drem_ff <= '0;
                  dneg_ff <= dsum_cur[63]; dbit_ff <= 6'd63;
                  div_first_ff <= 1'b0;
                  moved_ff <= (wsum_ff != '0) && (req_ff.vertex_mask != '0);
               end else begin
                  dnum_ff <= dnum_ff << 1;
                  if (rem_sh >= {1'b0, wsum_ff}) begin
                     drem_ff <= rem_sh - {1'b0, wsum_ff};
                     dquo_ff <= {dquo_ff[62:0], 1'b1};
                  end else begin
                     drem_ff <= rem_sh;
                     dquo_ff <= {dquo_ff[62:0], 1'b0};
                  end
                  if (dbit_ff == 6'd0) begin
                     div_first_ff <= 1'b1;
                     axis_ff <= axis_ff + 2'd1;
                  end else dbit_ff <= dbit_ff - 6'd1;
               end
               if (!div_first_ff && dbit_ff == 6'd0 && axis_ff == 2'd2) begin
                  wsum_ff <= '0;
                  for (int i = 0; i < 3; i++) dsum_ff[i] <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cap_ff <= 1'b0;
      else cap_ff <= (state_ff == ST_DIV) && !div_first_ff && dbit_ff == 6'd0;
      cap_axis_ff <= axis_ff;
   end
   logic signed [31:0] pos_cap;
   assign pos_cap = pos_axis_r(cap_axis_ff);
   always_ff @(posedge clock) begin
      if (cap_ff)
         res_ff[cap_axis_ff] <= moved_ff ?
            sat32(64'(pos_cap) + qs) : pos_cap;
   end

   // The sequencer never shows a response while taking a request.
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("ready during response");
   // A stalled response keeps its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");
   // A load returns to idle in the cycle after ST_LOAD.
   a_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |=> state_ff == ST_IDLE) else $error("load stuck");
endmodule
`default_nettype wire

// ----- tb/sv/lbs_checker.sv -----
`default_nettype none
// Watches both channels of the skinning block, keeps its own copy of the bone
// matrix table and the per-vertex accumulators, and checks every response
// against the oldest predicted vertex.
module lbs_checker (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire lbs_pkg::req_data_type req_tdata,
   input  wire logic                  req_tuser,
   input  wire logic                  req_tlast,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire lbs_pkg::rsp_data_type rsp_tdata,
   input  wire logic                  rsp_tuser,
   output int                         errors,
   output int                         pending,
   output int                         vertices_moved,
   output int                         vertices_passed
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               moved;
   } vertex_out_type;

   logic signed [31:0]          matrix_table [lbs_pkg::MAT_DEPTH];
   logic signed [63:0]          delta_acc [3];
   logic [lbs_pkg::WSUM_W-1:0]  weight_acc;
   vertex_out_type              vertex_q [$];

   function automatic logic signed [63:0] add_clip64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63])
         s = a[63] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
      return s;
   endfunction

   function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
      if (v > 64'sh000000007FFFFFFF) return 32'sh7FFFFFFF;
      if (v < 64'shFFFFFFFF80000000) return 32'sh80000000;
      return v[31:0];
   endfunction

   // Applies one request to the predicted state; returns 1 with the vertex
   // when the request closes a vertex.
   function automatic bit skin_request(input logic op, input lbs_pkg::req_data_type d,
                                       input logic lst, output vertex_out_type v);
      logic signed [63:0] p [3];
      logic signed [63:0] acc, t, dlt, qs;
      logic [63:0]        mag, q;
      logic [24:0]        wsum;
      int                 base;
      v = '0;
      if (op == lbs_pkg::OP_LOAD) begin
         if (d.word < lbs_pkg::MAT_WORDS)
            matrix_table[d.bone * lbs_pkg::MAT_WORDS + d.word] = d.matrix_word;
         return 0;
      end
      p[0] = d.pos_x;
      p[1] = d.pos_y;
      p[2] = d.pos_z;
      if (d.bone < lbs_pkg::BONES) begin
         base = d.bone * lbs_pkg::MAT_WORDS;
         for (int r = 0; r < 3; r++) begin
            acc = 64'(matrix_table[base + r*4 + 3]) <<< lbs_pkg::FRAC_BITS;
            for (int c = 0; c < 3; c++)
               acc = add_clip64(acc, 64'(matrix_table[base + r*4 + c]) * p[c]);
            t = clip32(acc >>> lbs_pkg::FRAC_BITS);
            dlt = t - p[r];
            delta_acc[r] = add_clip64(delta_acc[r], dlt * $signed({47'd0, d.weight}));
         end
         wsum = {1'b0, weight_acc} + d.weight;
         weight_acc = wsum[24] ? lbs_pkg::WSUM_MAX : wsum[23:0];
      end
      if (!lst) return 0;
      if (weight_acc != 0 && d.vertex_mask != 0) begin
         for (int r = 0; r < 3; r++) begin
            mag = delta_acc[r][63] ? 64'd0 - delta_acc[r] : delta_acc[r];
            q = mag / {40'd0, weight_acc};
            if (q > 64'd1 << 34) q = 64'd1 << 34;
            qs = delta_acc[r][63] ? -$signed(q) : $signed(q);
            p[r] = clip32(p[r] + qs);
         end
         v.moved = 1'b1;
      end
      v.x = p[0][31:0];
      v.y = p[1][31:0];
      v.z = p[2][31:0];
      for (int r = 0; r < 3; r++) delta_acc[r] = '0;
      weight_acc = '0;
      return 1;
   endfunction

   initial begin
      errors = 0;
      pending = 0;
      vertices_moved = 0;
      vertices_passed = 0;
      weight_acc = '0;
      for (int r = 0; r < 3; r++) delta_acc[r] = '0;
   end

   always @(posedge clock) begin
      vertex_out_type v, exp_v;
      if (reset) begin
         weight_acc = '0;
         for (int r = 0; r < 3; r++) delta_acc[r] = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (vertex_q.size() == 0) begin
               $display("%0t: response with no vertex pending: x=%h y=%h z=%h moved=%b",
                        $time, rsp_tdata.out_x, rsp_tdata.out_y, rsp_tdata.out_z,
                        rsp_tuser);
               errors++;
            end else begin
               exp_v = vertex_q.pop_front();
               if (rsp_tdata.out_x !== exp_v.x || rsp_tdata.out_y !== exp_v.y ||
                   rsp_tdata.out_z !== exp_v.z || rsp_tuser !== exp_v.moved) begin
                  $display("%0t: mismatch expected x=%h y=%h z=%h moved=%b", $time,
                           exp_v.x, exp_v.y, exp_v.z, exp_v.moved);
                  $display("%0t:          actual   x=%h y=%h z=%h moved=%b", $time,
                           rsp_tdata.out_x, rsp_tdata.out_y, rsp_tdata.out_z, rsp_tuser);
                  errors++;
               end
               if (exp_v.moved) vertices_moved++;
               else vertices_passed++;
            end
         end
         if (req_tvalid && req_tready)
            if (skin_request(req_tuser, req_tdata, req_tlast, v))
               vertex_q.push_back(v);
      end
      pending = vertex_q.size();
   end
endmodule
`default_nettype wire

// ----- tb/sv/tb_linear_blend_skinning_top.sv -----
`default_nettype none
// Stimulus and verdict for the skinning block. The checker beside the block
// does all prediction; this module only produces requests, throttles the
// response side and decides pass or fail.
module tb_linear_blend_skinning_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET = 950;
   // Cycles without any handshake before the run is declared hung. The slowest
   // legitimate stretch is a final influence behind a long receiver stall and
   // a long sender gap, so this leaves a wide margin.
   localparam int IDLE_LIMIT  = 5000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   lbs_pkg::req_data_type req_data = '0;
   logic                  req_tuser = lbs_pkg::OP_LOAD;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   lbs_pkg::rsp_data_type rsp_tdata;
   logic                  rsp_tuser;

   int errors, pending, vertices_moved, vertices_passed;
   int request_count = 0;
   int idle_cycles = 0;
   bit quiet_sender = 0;
   // One bit per matrix word that has been written. An influence only uses a
   // bone whose twelve words are all written, since unwritten words are
   // undefined in the block.
   logic [11:0] words_written [lbs_pkg::BONES];

   always #5 clock = ~clock;

   linear_blend_skinning_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_data),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   lbs_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_data),
      .req_tuser      (req_tuser),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .errors         (errors),
      .pending        (pending),
      .vertices_moved (vertices_moved),
      .vertices_passed(vertices_passed)
   );

   // The watchdog restarts on every accepted request or response.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Response side: the receiver switches between always ready, random short
   // stalls and long stalls, so that stalls land on every phase.
   int sink_mode = 0;
   int sink_hold = 0;
   int sink_mode_left = 0;
   always @(negedge clock) begin
      if (sink_mode_left == 0) begin
         sink_mode = $urandom_range(0, 2);
         sink_mode_left = $urandom_range(50, 400);
      end else begin
         sink_mode_left--;
      end
      if (sink_hold > 0) begin
         sink_hold--;
         rsp_tready <= 1'b0;
      end else if (sink_mode == 0) begin
         rsp_tready <= 1'b1;
      end else if ($urandom_range(0, 99) < 85) begin
         rsp_tready <= 1'b1;
      end else begin
         // Most stalls are short; in the third mode some run long.
         sink_hold = (sink_mode == 2 && $urandom_range(0, 3) == 0) ?
                     $urandom_range(15, 60) : $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end
   end

   function automatic int gap_length();
      int r;
      if (quiet_sender) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   // Presents one request at the falling edge and holds it until the block
   // takes it at a rising edge, then leaves an optional gap.
   task automatic send_request(input logic op, input lbs_pkg::req_data_type d,
                               input logic lst);
      int gap;
      req_data   <= d;
      req_tuser  <= op;
      req_tlast  <= lst;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      request_count++;
      if (op == lbs_pkg::OP_LOAD && d.word < lbs_pkg::MAT_WORDS)
         words_written[d.bone][d.word] = 1'b1;
      @(negedge clock);
      gap = gap_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic load_word(input int bone, input int word, input logic signed [31:0] value);
      lbs_pkg::req_data_type d;
      d = '0;
      d.bone = 6'(bone);
      d.word = 4'(word);
      d.matrix_word = value;
      // Position and weight fields are don't-care for a load; fill pos_x and the
      // weight with noise so that the block is seen to ignore them.
      d.pos_x = $urandom();
      d.weight = 17'($urandom_range(0, 65536));
      send_request(lbs_pkg::OP_LOAD, d, 1'($urandom_range(0, 1)));
   endtask

   task automatic influence(input int bone, input logic signed [31:0] x,
                            input logic signed [31:0] y, input logic signed [31:0] z,
                            input int weight, input int mask, input logic lst);
      lbs_pkg::req_data_type d;
      d = '0;
      d.bone = 6'(bone);
      d.word = 4'($urandom_range(0, 15));
      d.matrix_word = $urandom();
      d.pos_x = x;
      d.pos_y = y;
      d.pos_z = z;
      d.weight = 17'(weight);
      d.vertex_mask = 17'(mask);
      send_request(lbs_pkg::OP_INFLUENCE, d, lst);
   endtask

   // Matrix entry: mostly a near-rigid transform, sometimes any 32-bit value.
   function automatic logic signed [31:0] matrix_entry(input int word);
      if ($urandom_range(0, 7) == 0) return $urandom();
      if (word % 4 == 3) return $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
      if (word / 4 == word % 4)
         return 32'sh0001_0000 + $signed($urandom_range(0, 32'h4000)) - 32'sh2000;
      return $signed($urandom_range(0, 32'h8000)) - 32'sh4000;
   endfunction

   // Coordinate: mostly within a few hundred units, sometimes anywhere.
   function automatic logic signed [31:0] coordinate();
      if ($urandom_range(0, 9) == 0) return $urandom();
      return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
   endfunction

   function automatic int random_weight();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 0;
      if (r == 1) return 65536;
      return $urandom_range(1, 65535);
   endfunction

   function automatic int ready_bone();
      int b;
      repeat (20) begin
         b = $urandom_range(0, lbs_pkg::BONES - 1);
         if (words_written[b] == 12'hFFF) return b;
      end
      return 0;
   endfunction

   task automatic random_vertex(input int influences);
      logic signed [31:0] x, y, z;
      int mask;
      mask = ($urandom_range(0, 9) == 0) ? 0 :
             ($urandom_range(0, 9) == 0) ? 65536 : $urandom_range(1, 65535);
      for (int i = 0; i < influences; i++) begin
         x = coordinate();
         y = coordinate();
         z = coordinate();
         influence(ready_bone(), x, y, z, random_weight(), mask, i == influences - 1);
      end
   endtask

   // The request already taken must not stay offered while the sender waits.
   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      int vertex_count;
      int pick;
      int bone;
      for (int b = 0; b < lbs_pkg::BONES; b++) words_written[b] = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Bone 0 is the identity; bone 63 carries extreme entries that drive
      // the transform sum and the transformed coordinate into saturation.
      for (int w = 0; w < 12; w++)
         load_word(0, w, (w / 4 == w % 4) ? 32'sh0001_0000 : 32'sh0);
      for (int w = 0; w < 12; w++)
         load_word(63, w, (w % 2) ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
      // Words past the end of a matrix are ignored.
      load_word(0, 12, 32'sh1234_5678);
      load_word(0, 15, 32'sh8000_0000);

      // Directed vertices: identity with full weight, zero weight and zero
      // mask (both pass the position through), saturation at the extremes of
      // the position, a blend of two bones, and the full weight range.
      influence(0, 32'sh0001_0000, -32'sh0002_0000, 32'sh7FFF_FFFF, 65536, 65536, 1'b1);
      influence(63, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 0, 65536, 1'b1);
      influence(63, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 65536, 0, 1'b1);
      influence(63, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 65536, 65536, 1'b1);
      influence(63, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1, 1, 1'b1);
      influence(0, 32'sh0003_0000, 32'sh0004_0000, 32'sh0005_0000, 16384, 65535, 1'b0);
      influence(63, 32'sh0003_0000, 32'sh0004_0000, 32'sh0005_0000, 49152, 65535, 1'b1);
      influence(63, -32'sh1, 32'sh0, 32'sh1, 65535, 1, 1'b0);
      influence(0, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sh1, 1, 65536, 1'b1);
      wait_for_responses();

      // Random part: mostly well-formed vertices of one to four influences,
      // with matrix reloads between them and stray loads as noise.
      vertex_count = 0;
      while (request_count < ITEM_TARGET) begin
         if ($urandom_range(0, 29) == 0) quiet_sender = ~quiet_sender;
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            bone = $urandom_range(0, lbs_pkg::BONES - 1);
            for (int w = 0; w < 12; w++) load_word(bone, w, matrix_entry(w));
         end else if (pick < 17) begin
            load_word($urandom_range(0, lbs_pkg::BONES - 1), $urandom_range(0, 15),
                      $urandom());
         end else begin
            random_vertex($urandom_range(1, 4));
            vertex_count++;
            // Once, let the block drain completely before going on.
            if (vertex_count == 60) wait_for_responses();
            // Once, a vertex long enough to saturate the weight sum.
            if (vertex_count == 120) begin
               for (int i = 0; i < 260; i++)
                  influence(ready_bone(), coordinate(), coordinate(), coordinate(),
                            65536, 65536, i == 259);
            end
         end
      end

      req_tvalid <= 1'b0;
      wait_for_responses();
      repeat (20) @(posedge clock);

      $display("Sent %0d requests; %0d vertices deformed and %0d passed through.",
               request_count, vertices_moved, vertices_passed);
      $display("Covered matrix loads with ignored words, blends, zero weights and masks.");
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", errors);
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
